FILE: design/button_click_classifier_top_assert.svh
// assertion macros shared by the button click classifier modules
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define BCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcc assertion failed");
// next-cycle implication, checked outside reset
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcc assertion failed");
`else
`define BCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/bcc_pkg.sv
// shared types and constants for the button click classifier
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    // press tracking phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2
    } t_phase;

    // event codes on the result channel
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } t_event;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS_TICKS   = 2'd1;
    localparam logic [1:0] CFG_DOUBLE_CLICK_TICKS = 2'd2;

    // configuration reset values
    localparam logic [7:0]  DEBOUNCE_THRESHOLD_RST = 8'd1;
    localparam logic [15:0] LONG_PRESS_TICKS_RST   = 16'd20;
    localparam logic [15:0] DOUBLE_CLICK_TICKS_RST = 16'd10;

    // configuration set handed to the core
    typedef struct packed {
        logic [7:0]  debounce_threshold;
        logic [15:0] long_press_ticks;
        logic [15:0] double_click_ticks;
    } t_cfg;

endpackage

`default_nettype wire

FILE: design/bcc_core.sv
// press classifier state and per-tick event logic
`timescale 1ns / 1ps
`default_nettype none
`include "button_click_classifier_top_assert.svh"

module bcc_core
    import bcc_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_step,
    input  wire logic   i_pin_level,
    input  wire t_cfg   i_cfg,
    output t_event      o_event_code
);

    localparam int CmpW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

    t_phase                        r_phase, n_phase;
    logic [7:0]                    r_deb_count, n_deb_count;
    logic [TICK_COUNT_WIDTH-1:0]   r_held, n_held;
    logic                          r_long_reported, n_long_reported;
    logic [1:0]                    r_clicks, n_clicks;
    logic [TICK_COUNT_WIDTH-1:0]   r_wait, n_wait;

    logic                          pressed;
    logic [7:0]                    deb_next;
    logic                          deb_done;
    logic [TICK_COUNT_WIDTH-1:0]   held_next;
    logic [CmpW-1:0]               long_ext;
    logic [CmpW-1:0]               dbl_ext;
    logic                          held_next_hit;
    logic                          held_cur_hit;
    logic [TICK_COUNT_WIDTH-1:0]   wait_dec;
    logic [1:0]                    clicks_aged;
    logic [1:0]                    clicks_inc;
    t_event                        ev;

    // shared counter helpers
    assign pressed       = ~i_pin_level;
    assign deb_next      = (r_deb_count == 8'hFF) ? r_deb_count : r_deb_count + 8'd1;
    assign deb_done      = deb_next >= i_cfg.debounce_threshold;
    assign held_next     = (&r_held) ? r_held : r_held + 1'b1;
    assign long_ext      = CmpW'(i_cfg.long_press_ticks);
    assign dbl_ext       = CmpW'(i_cfg.double_click_ticks);
    assign held_next_hit = CmpW'(held_next) >= long_ext;
    assign held_cur_hit  = CmpW'(r_held) >= long_ext;
    assign wait_dec      = r_wait - 1'b1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (pressed) n_phase = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
                if (!pressed)     n_phase = PH_IDLE;
                else if (deb_done) n_phase = PH_PRESSED;
            end
            PH_PRESSED: begin
                if (!pressed) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // counters, click tracking and event
    always_comb begin
        n_deb_count     = r_deb_count;
        n_held          = r_held;
        n_long_reported = r_long_reported;
        n_wait          = r_wait;
        clicks_aged     = r_clicks;
        ev              = EV_NONE;

        // age the double click timer first
        if (r_wait != '0) begin
            n_wait = wait_dec;
            if (wait_dec == '0) begin
                if (r_clicks == 2'd1) ev = EV_SHORT;
                clicks_aged = 2'd0;
            end
        end

        n_clicks   = clicks_aged;
        clicks_inc = (clicks_aged == 2'd3) ? clicks_aged : clicks_aged + 2'd1;

        unique case (r_phase)
            PH_IDLE: begin
                if (pressed) n_deb_count = 8'd1;
            end
            PH_DEBOUNCE: begin
                if (pressed) begin
                    n_deb_count = deb_next;
                    if (deb_done) n_held = '0;
                end
            end
            PH_PRESSED: begin
                if (pressed) begin
                    n_held = held_next;
                    if (held_next_hit && !r_long_reported) begin
                        ev              = EV_LONG;
                        n_long_reported = 1'b1;
                        n_clicks        = 2'd0;
                    end
                end else begin
                    // a short release counts as a click
                    if (!held_cur_hit && !r_long_reported) begin
                        n_clicks = clicks_inc;
                        if (clicks_inc == 2'd1) begin
                            n_wait = dbl_ext[TICK_COUNT_WIDTH-1:0];
                        end else if (clicks_inc == 2'd2) begin
                            ev       = EV_DOUBLE;
                            n_clicks = 2'd0;
                            n_wait   = '0;
                        end
                    end
                    n_long_reported = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_event_code = ev;

    // state registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_deb_count     <= '0;
            r_held          <= '0;
            r_long_reported <= 1'b0;
            r_clicks        <= '0;
            r_wait          <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_deb_count     <= n_deb_count;
            r_held          <= n_held;
            r_long_reported <= n_long_reported;
            r_clicks        <= n_clicks;
            r_wait          <= n_wait;
        end
    end

    // a reported long press only lives while the key is held
    `BCC_ASSERT_IMPL(a_long_in_pressed, i_clk, i_rst_n, r_long_reported, r_phase == PH_PRESSED)
    // a second click is always turned into a double click at once
    `BCC_ASSERT_IMPL(a_clicks_le_one, i_clk, i_rst_n, 1'b1, r_clicks[1] == 1'b0)
    // double click only on a release from the pressed phase
    `BCC_ASSERT_IMPL(a_double_on_release, i_clk, i_rst_n, i_step && ev == EV_DOUBLE,
                     r_phase == PH_PRESSED && i_pin_level)

endmodule

`default_nettype wire

FILE: design/bcc_out_buf.sv
// two-entry result buffer: output register plus skid stage
`timescale 1ns / 1ps
`default_nettype none
`include "button_click_classifier_top_assert.svh"

module bcc_out_buf
    import bcc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_event i_code,
    output logic        o_full,
    output logic        o_valid,
    output t_event      o_code,
    input  wire logic   i_stall
);

    logic   r_out_valid, n_out_valid;
    logic   r_skid_valid, n_skid_valid;
    t_event r_out_code, n_out_code;
    t_event r_skid_code, n_skid_code;
    logic   pop;

    assign pop = r_out_valid && !i_stall;

    // buffer next state
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_code   = r_out_code;
        n_skid_code  = r_skid_code;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_code   = r_skid_code;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out_valid = 1'b1;
                n_out_code  = i_code;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid_code  = i_code;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out_code  <= n_out_code;
        r_skid_code <= n_skid_code;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_code  = r_out_code;

    // skid entry is only used behind a held output
    `BCC_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // a beat pushed against a stalled output lands in the skid stage
    `BCC_ASSERT_NEXT(a_push_to_skid, i_clk, i_rst_n, i_push && r_out_valid && i_stall,
                     r_skid_valid)

endmodule

`default_nettype wire

FILE: design/button_click_classifier_top.sv
// top level of the button click classifier
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | in        | i_in_valid / o_in_stall | i_pin_level
//  out     | out       | o_out_valid / i_out_stall | o_event_code
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one tick per clock while o_in_stall is low: the classifier state updates
// on the accepting edge and its event enters the result buffer on that edge
// throughput is one beat per clock until a full skid stage raises o_in_stall
// reset is synchronous, active low, clears state and flags, presets config registers
// a stalled output holds its beat; one more beat fits in the skid stage,
// after which o_in_stall rises until the output drains
// config writes are always ready and take effect on the next tick
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier_top
    import bcc_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_pin_level,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_event_code,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   in_accept;
    logic   buf_full;
    t_event core_event;
    t_event out_code;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign in_accept   = i_in_valid && !buf_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_threshold <= DEBOUNCE_THRESHOLD_RST;
            r_cfg.long_press_ticks   <= LONG_PRESS_TICKS_RST;
            r_cfg.double_click_ticks <= DOUBLE_CLICK_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_THRESHOLD: r_cfg.debounce_threshold <= i_cfg_data[7:0];
                CFG_LONG_PRESS_TICKS:   r_cfg.long_press_ticks   <= i_cfg_data;
                CFG_DOUBLE_CLICK_TICKS: r_cfg.double_click_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // classifier state
    bcc_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_accept),
        .i_pin_level  (i_pin_level),
        .i_cfg        (r_cfg),
        .o_event_code (core_event)
    );

    // result register and skid
    bcc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_code  (core_event),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_code  (out_code),
        .i_stall (i_out_stall)
    );

    assign o_event_code = out_code;

endmodule

`default_nettype wire
